/* rtl/core/assert_macros.svh */
// Assertion macros shared by the compressor RTL.
// Included by the top level; compiles to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPC_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define SPC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define SPC_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define SPC_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/spc_pkg.sv */
// Constants, register map and table generator functions for the compressor.
// No dependencies; used by spc_tab_rom and stereo_peak_compressor.
`default_nettype none
package spc_pkg;

    localparam int RATIO_W    = 16;
    localparam int RATIO_FRAC = 15;
    localparam int OGAIN_W    = 23;
    localparam int OGAIN_FRAC = 16;
    localparam int APB_DATA_W = 32;
    localparam int REG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RATIO     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ENV_REL   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OUT_GAIN  = 3'd5;

    localparam logic [63:0] ONE30 = 64'd1 << 30;

    typedef logic [63:0] u64_t;

    function automatic u64_t spc_isqrt(input u64_t n_in);
        u64_t n;
        u64_t r;
        u64_t b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > n) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic u64_t spc_align30(input u64_t x, input int cw);
        if (cw <= 30) return x >> (30 - cw);
        return x << (cw - 30);
    endfunction

    // log2(1+f) by repeated squaring, f in Q0.30
    function automatic u64_t spc_log_entry(input u64_t f, input int cw);
        u64_t x;
        u64_t res;
        x = ONE30 + f;
        res = '0;
        for (int k = 1; k <= 30; k++) begin
            x = (x * x) >> 30;
            res = res << 1;
            if (x >= 2 * ONE30) begin
                x = x >> 1;
                res = res | 64'd1;
            end
        end
        return spc_align30(res, cw);
    endfunction

    // 2^f as a product of 2^(2^-k) roots, f in Q0.30
    function automatic u64_t spc_exp_entry(input u64_t f, input int cw);
        u64_t roots [0:30];
        u64_t acc;
        roots[0] = ONE30 * 2;
        for (int k = 1; k <= 30; k++) roots[k] = spc_isqrt(roots[k-1] << 30);
        acc = ONE30;
        for (int k = 1; k <= 30; k++) begin
            if (f[30-k]) acc = (acc * roots[k]) >> 30;
        end
        return spc_align30(acc, cw);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/spc_tab_rom.sv */
// Constant log2 / exp2 interpolation table with a registered read port.
// Depends on spc_pkg for the entry generator functions.
`default_nettype none
module spc_tab_rom
    import spc_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int CW     = 24,
    parameter bit IS_EXP = 1'b0
) (
    input  wire logic                       aclk,
    input  wire logic [$clog2(DEPTH+1)-1:0] rd_addr,
    output logic      [CW+1:0]              rd_data
);
    localparam int TW = CW + 2;

    logic [TW-1:0] tab [0:DEPTH];
    logic [TW-1:0] rd_data_reg;

    for (genvar i = 0; i <= DEPTH; i++) begin : g_ent
        localparam logic [63:0] F = (64'(i) << 30) / DEPTH;
        if (i == DEPTH) begin : g_last
            assign tab[i] = IS_EXP ? (TW'(2) << CW) : (TW'(1) << CW);
        end else if (IS_EXP) begin : g_exp
            localparam logic [63:0] V = spc_exp_entry(F, CW);
            assign tab[i] = V[TW-1:0];
        end else begin : g_log
            localparam logic [63:0] V = spc_log_entry(F, CW);
            assign tab[i] = V[TW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= tab[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* rtl/core/stereo_peak_compressor.sv */
// Stereo peak compressor top level: APB register file, sequencer and shared multiplier.
// Depends on spc_pkg, spc_tab_rom and assert_macros.svh.
//
//   channel  | handshake          | words
//   s_       | s_valid / s_ready  | left and right sample in
//   m_       | m_valid / m_ready  | left, right result and smoothed gain out
//   apb      | psel/penable/pready| six config registers at 4*i
//
// A frame is accepted only once the sequencer has finished the one before, as the single
// multiplier serves every product in turn.
// s_ready is high only when the sequencer is idle. The result sits in an output
// register, so the next frame is taken while it waits; the last step holds until
// that register is free. Reset is synchronous and needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module stereo_peak_compressor
    import spc_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = 24,
    parameter int COEF_WIDTH      = 24,
    parameter int LOG_TABLE_DEPTH = 256
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_left_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_right_sample,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      m_left_result,
    output logic signed [SAMPLE_WIDTH-1:0]      m_right_result,
    output logic        [COEF_WIDTH-1:0]        m_gain_now,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [REG_ADDR_W-1:0]          paddr,
    input  wire logic [APB_DATA_W-1:0]          pwdata,
    output logic      [APB_DATA_W-1:0]          prdata,
    output logic                                pready
);
    localparam int CW    = COEF_WIDTH;
    localparam int SW    = SAMPLE_WIDTH;
    localparam int DEPTH = LOG_TABLE_DEPTH;
    localparam int TW    = CW + 2;
    localparam int LW    = CW + 6;
    localparam int XW    = CW + 1;
    localparam int AW    = $clog2(DEPTH + 1);
    localparam int PW    = XW + AW;
    localparam int PCW   = $clog2(CW);
    localparam int SAW   = $clog2(CW + 1);
    localparam int NW    = LW - CW + 1;
    localparam int EW    = ((SW > CW) ? SW : CW) + 1;
    localparam int SH_UP = (CW >= SW - 1) ? CW - SW + 1 : 0;
    localparam int SH_DN = (CW >= SW - 1) ? 0 : SW - 1 - CW;
    localparam int MA_W  = (LW > SW) ? LW : SW;
    localparam int MB_W  = (XW > OGAIN_W) ? XW : OGAIN_W;
    localparam int MP_W  = MA_W + MB_W;
    localparam int MGW   = MP_W - OGAIN_FRAC;

    localparam logic [CW-1:0] C_ONES = '1;
    localparam logic [XW-1:0] ONE_X  = XW'(1) << CW;

    localparam logic [CW-1:0]      THR_RST  = CW'(32'd16777215);
    localparam logic [CW-1:0]      ATK_RST  = CW'(32'd16581375);
    localparam logic [CW-1:0]      REL_RST  = CW'(32'd16770000);
    localparam logic [CW-1:0]      EREL_RST = CW'(32'd16700000);
    localparam logic [OGAIN_W-1:0] OG_RST   = OGAIN_W'(32'd65536);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_INNER_M = 5'd1;
    localparam logic [4:0] S_INNER_W = 5'd2;
    localparam logic [4:0] S_OUTER_M = 5'd3;
    localparam logic [4:0] S_OUTER_W = 5'd4;
    localparam logic [4:0] S_DECIDE  = 5'd5;
    localparam logic [4:0] S_I0      = 5'd6;
    localparam logic [4:0] S_I1      = 5'd7;
    localparam logic [4:0] S_I2      = 5'd8;
    localparam logic [4:0] S_I3      = 5'd9;
    localparam logic [4:0] S_EXP_M   = 5'd10;
    localparam logic [4:0] S_EXP_W   = 5'd11;
    localparam logic [4:0] S_GAIN_M  = 5'd12;
    localparam logic [4:0] S_GAIN_W  = 5'd13;
    localparam logic [4:0] S_OUT_L1  = 5'd14;
    localparam logic [4:0] S_OUT_L2  = 5'd15;
    localparam logic [4:0] S_OUT_R1  = 5'd16;
    localparam logic [4:0] S_OUT_R2  = 5'd17;
    localparam logic [4:0] S_OUT_W   = 5'd18;

    localparam logic [1:0] PH_LOGENV = 2'd0;
    localparam logic [1:0] PH_LOGTHR = 2'd1;
    localparam logic [1:0] PH_EXP    = 2'd2;

    // configuration
    logic [CW-1:0]      threshold_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [CW-1:0]      attack_reg;
    logic [CW-1:0]      release_reg;
    logic [CW-1:0]      env_rel_reg;
    logic [OGAIN_W-1:0] out_gain_reg;

    // control and filter state
    logic [4:0]    state_reg;
    logic [4:0]    state_next;
    logic [1:0]    phase_reg;
    logic          m_valid_reg;
    logic [CW-1:0] inner_reg;
    logic [CW-1:0] outer_reg;
    logic [CW-1:0] sg_reg;

    // payload
    logic [SW-1:0]   smp_l_reg;
    logic [SW-1:0]   smp_r_reg;
    logic [CW-1:0]   env_reg;
    logic [PCW-1:0]  p_reg;
    logic [XW-1:0]   x_reg;
    logic [CW-1:0]   fr_reg;
    logic [AW-1:0]   idx1_reg;
    logic [TW-1:0]   t0_reg;
    logic            up_reg;
    logic [LW-1:0]   d_reg;
    logic [NW-1:0]   n_reg;
    logic [CW-1:0]   target_reg;
    logic [MP_W-1:0] prod_reg;
    logic [SW-1:0]   left_tmp_reg;
    logic [SW-1:0]   m_left_reg;
    logic [SW-1:0]   m_right_reg;
    logic [CW-1:0]   m_gain_reg;

    logic             cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic             in_acc;
    logic             out_free;
    logic [CW-1:0]    env_in;
    logic [CW-1:0]    thr_eff;
    logic [CW-1:0]    lz_in;
    logic [PCW-1:0]   p_calc;
    logic [SAW-1:0]   sh_amt;
    logic [CW-1:0]    m_calc;
    logic [PW-1:0]    pos;
    logic [AW-1:0]    idx;
    logic [AW-1:0]    idx1;
    logic [AW-1:0]    rom_addr;
    logic [TW-1:0]    log_q;
    logic [TW-1:0]    exp_q;
    logic [TW-1:0]    rom_q;
    logic             t_up;
    logic [TW-1:0]    i_step;
    logic [TW-1:0]    iv;
    logic [LW-1:0]    lv;
    logic [LW-1:0]    e_val;
    logic [TW-1:0]    tv;
    logic [CW-1:0]    target_calc;
    logic             gain_up;
    logic [XW-1:0]    g_eff;
    logic [RATIO_W-1:0] neg_ratio;
    logic [MA_W-1:0]  mul_a;
    logic [MB_W-1:0]  mul_b;
    logic [SW-1:0]    right_sat;

    function automatic logic [CW-1:0] env_of(input logic [SW-1:0] v);
        logic [SW-1:0] mag;
        logic [EW-1:0] sh;
        mag = v[SW-1] ? (~v + 1'b1) : v;
        sh = (EW'(mag) << SH_UP) >> SH_DN;
        if (sh > EW'(C_ONES)) return C_ONES;
        if (sh == '0) return CW'(1);
        return sh[CW-1:0];
    endfunction

    function automatic logic [SW-1:0] mag_of(input logic [SW-1:0] v);
        return v[SW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [SW-1:0] sat_of(input logic [MP_W-1:0] p, input logic neg);
        logic [MGW-1:0] m;
        logic [SW-1:0]  t;
        m = p[MP_W-1:OGAIN_FRAC];
        if (neg) begin
            if (m > (MGW'(1) << (SW - 1))) m = MGW'(1) << (SW - 1);
            t = m[SW-1:0];
            return ~t + 1'b1;
        end
        if (m > ((MGW'(1) << (SW - 1)) - 1'b1)) m = (MGW'(1) << (SW - 1)) - 1'b1;
        return m[SW-1:0];
    endfunction

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[REG_ADDR_W-1:2];
    assign pready   = 1'b1;
    assign s_ready  = (state_reg == S_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_left_result  = m_left_reg;
    assign m_right_result = m_right_reg;
    assign m_gain_now     = m_gain_reg;

    always_comb begin
        case (cfg_idx)
            REG_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            REG_RATIO:     prdata = APB_DATA_W'(ratio_reg);
            REG_ATTACK:    prdata = APB_DATA_W'(attack_reg);
            REG_RELEASE:   prdata = APB_DATA_W'(release_reg);
            REG_ENV_REL:   prdata = APB_DATA_W'(env_rel_reg);
            REG_OUT_GAIN:  prdata = APB_DATA_W'(out_gain_reg);
            default:       prdata = '0;
        endcase
    end

    assign env_in  = (env_of(s_left_sample) > env_of(s_right_sample)) ?
                     env_of(s_left_sample) : env_of(s_right_sample);
    assign thr_eff = (threshold_reg == '0) ? CW'(1) : threshold_reg;

    // leading-one position and mantissa for log2
    assign lz_in = (state_reg == S_DECIDE) ? outer_reg : thr_eff;
    always_comb begin
        p_calc = '0;
        for (int i = 0; i < CW; i++) begin
            if (lz_in[i]) p_calc = PCW'(i);
        end
    end
    assign sh_amt = SAW'(CW) - SAW'(p_calc);
    assign m_calc = lz_in << sh_amt;

    // table interpolation
    assign pos      = PW'(x_reg) * PW'(DEPTH);
    assign idx      = pos[CW +: AW];
    assign idx1     = (idx >= AW'(DEPTH)) ? AW'(DEPTH) : idx + 1'b1;
    assign rom_addr = (state_reg == S_I0) ? idx : idx1_reg;
    assign rom_q    = (phase_reg == PH_EXP) ? exp_q : log_q;
    assign t_up     = (rom_q >= t0_reg);
    assign i_step   = prod_reg[CW +: TW];
    assign iv       = up_reg ? t0_reg + i_step : t0_reg - i_step;
    assign lv       = (LW'(p_reg) << CW) + LW'(iv);
    assign e_val    = prod_reg[RATIO_FRAC +: LW];
    assign tv       = iv >> n_reg;
    assign target_calc = (n_reg > NW'(CW + 2)) ? '0 :
                         ((tv > TW'(C_ONES)) ? C_ONES : tv[CW-1:0]);

    assign gain_up   = (sg_reg < target_reg);
    assign g_eff     = (sg_reg == C_ONES) ? ONE_X : XW'(sg_reg);
    assign neg_ratio = ~ratio_reg + 1'b1;
    assign right_sat = sat_of(prod_reg, smp_r_reg[SW-1]);

    spc_tab_rom #(.DEPTH(DEPTH), .CW(CW), .IS_EXP(1'b0)) u_log_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (log_q)
    );

    spc_tab_rom #(.DEPTH(DEPTH), .CW(CW), .IS_EXP(1'b1)) u_exp_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (exp_q)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_INNER_M: begin
                mul_a = MA_W'(inner_reg - env_reg);
                mul_b = MB_W'(env_rel_reg);
            end
            S_OUTER_M: begin
                mul_a = MA_W'(outer_reg - inner_reg);
                mul_b = MB_W'(env_rel_reg);
            end
            S_I2: begin
                mul_a = MA_W'(t_up ? rom_q - t0_reg : t0_reg - rom_q);
                mul_b = MB_W'(fr_reg);
            end
            S_EXP_M: begin
                mul_a = MA_W'(d_reg);
                mul_b = MB_W'(neg_ratio);
            end
            S_GAIN_M: begin
                mul_a = MA_W'(gain_up ? target_reg - sg_reg : sg_reg - target_reg);
                mul_b = MB_W'(gain_up ? release_reg : attack_reg);
            end
            S_OUT_L1: begin
                mul_a = MA_W'(mag_of(smp_l_reg));
                mul_b = MB_W'(g_eff);
            end
            S_OUT_R1: begin
                mul_a = MA_W'(mag_of(smp_r_reg));
                mul_b = MB_W'(g_eff);
            end
            S_OUT_L2, S_OUT_R2: begin
                mul_a = MA_W'(prod_reg[CW +: SW]);
                mul_b = MB_W'(out_gain_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_acc) state_next = S_INNER_M;
            S_INNER_M: state_next = S_INNER_W;
            S_INNER_W: state_next = S_OUTER_M;
            S_OUTER_M: state_next = S_OUTER_W;
            S_OUTER_W: state_next = S_DECIDE;
            S_DECIDE: begin
                if (outer_reg > thr_eff && ratio_reg[RATIO_W-1]) state_next = S_I0;
                else state_next = S_GAIN_M;
            end
            S_I0:      state_next = S_I1;
            S_I1:      state_next = S_I2;
            S_I2:      state_next = S_I3;
            S_I3: begin
                case (phase_reg)
                    PH_LOGENV: state_next = S_I0;
                    PH_LOGTHR: state_next = S_EXP_M;
                    default:   state_next = S_GAIN_M;
                endcase
            end
            S_EXP_M:   state_next = S_EXP_W;
            S_EXP_W:   state_next = S_I0;
            S_GAIN_M:  state_next = S_GAIN_W;
            S_GAIN_W:  state_next = S_OUT_L1;
            S_OUT_L1:  state_next = S_OUT_L2;
            S_OUT_L2:  state_next = S_OUT_R1;
            S_OUT_R1:  state_next = S_OUT_R2;
            S_OUT_R2:  state_next = S_OUT_W;
            S_OUT_W:   if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // control, configuration and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            threshold_reg <= THR_RST;
            ratio_reg     <= '0;
            attack_reg    <= ATK_RST;
            release_reg   <= REL_RST;
            env_rel_reg   <= EREL_RST;
            out_gain_reg  <= OG_RST;
            inner_reg     <= '0;
            outer_reg     <= '0;
            sg_reg        <= C_ONES;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_THRESHOLD: threshold_reg <= pwdata[CW-1:0];
                    REG_RATIO:     ratio_reg     <= pwdata[RATIO_W-1:0];
                    REG_ATTACK:    attack_reg    <= pwdata[CW-1:0];
                    REG_RELEASE:   release_reg   <= pwdata[CW-1:0];
                    REG_ENV_REL:   env_rel_reg   <= pwdata[CW-1:0];
                    REG_OUT_GAIN:  out_gain_reg  <= pwdata[OGAIN_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_OUT_W && out_free) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (state_reg == S_INNER_W) begin
                inner_reg <= (inner_reg < env_reg) ? env_reg : env_reg + prod_reg[CW +: CW];
            end
            if (state_reg == S_OUTER_W) begin
                outer_reg <= (outer_reg < inner_reg) ? inner_reg :
                             inner_reg + prod_reg[CW +: CW];
            end
            if (state_reg == S_GAIN_W) begin
                sg_reg <= gain_up ? target_reg - prod_reg[CW +: CW] :
                                    target_reg + prod_reg[CW +: CW];
            end
        end
    end

    // datapath words
    always_ff @(posedge aclk) begin
        // right product is held while the finished word waits for the output register
        if (state_reg != S_OUT_W) prod_reg <= MP_W'(mul_a) * MP_W'(mul_b);
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    smp_l_reg <= s_left_sample;
                    smp_r_reg <= s_right_sample;
                    env_reg   <= env_in;
                end
            end
            S_DECIDE: begin
                target_reg <= C_ONES;
                p_reg      <= p_calc;
                x_reg      <= XW'(m_calc);
                phase_reg  <= PH_LOGENV;
            end
            S_I0: begin
                fr_reg   <= pos[CW-1:0];
                idx1_reg <= idx1;
            end
            S_I1: t0_reg <= rom_q;
            S_I2: up_reg <= t_up;
            S_I3: begin
                case (phase_reg)
                    PH_LOGENV: begin
                        d_reg     <= lv;
                        p_reg     <= p_calc;
                        x_reg     <= XW'(m_calc);
                        phase_reg <= PH_LOGTHR;
                    end
                    PH_LOGTHR: d_reg <= (d_reg > lv) ? d_reg - lv : '0;
                    default:   target_reg <= target_calc;
                endcase
            end
            S_EXP_W: begin
                n_reg     <= NW'(e_val[LW-1:CW]) + 1'b1;
                x_reg     <= ONE_X - XW'(e_val[CW-1:0]);
                phase_reg <= PH_EXP;
            end
            S_OUT_R1: left_tmp_reg <= sat_of(prod_reg, smp_l_reg[SW-1]);
            S_OUT_W: begin
                if (out_free) begin
                    m_left_reg  <= left_tmp_reg;
                    m_right_reg <= right_sat;
                    m_gain_reg  <= sg_reg;
                end
            end
            default: ;
        endcase
    end

    `SPC_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg == S_INNER_M)
    `SPC_ASSERT_IMPL(a_result_from_end, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == S_OUT_W)
    `SPC_ASSERT_NEXT(a_inner_tracks, aclk, aresetn, state_reg == S_INNER_W, inner_reg >= env_reg)
    `SPC_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, state_reg == S_OUT_W && !out_free, state_reg == S_OUT_W)

endmodule
`default_nettype wire
